@@ rtl/efct_pkg.sv @@
// ----------------------------------------------------------------------------
// efct_pkg
// Shared constants, register indexes, width helpers and the control struct
// of the exhalation flow cycle trigger.
// ----------------------------------------------------------------------------
package efct_pkg;

  localparam int FLOW_SCALE_DEF = 100;
  localparam int FLOW_WIDTH_DEF = 24;

  localparam int PCT_W     = 7;
  localparam int BIAS_W    = 23;
  localparam int INIT_W    = 10;
  localparam int LEAK_IN_W = 16;
  localparam int TICKS_W   = 16;
  localparam int LIM_W     = 25;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_EXH_SENS_PCT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_FLOW        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PHASE_TICKS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NIV_MODE         = 4'd3;

  localparam logic [PCT_W-1:0]  PCT_MAX        = 7'd100;
  localparam logic [PCT_W-1:0]  SENS_RESET     = 7'd25;
  localparam logic [BIAS_W-1:0] BIAS_RESET     = 23'd10;
  localparam logic [INIT_W-1:0] INIT_RESET     = 10'd100;

  typedef struct packed {
    logic enable;
    logic active;
  } efct_ctl_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int leak_w(input int fs);
    return LEAK_IN_W + $clog2(fs);
  endfunction

  function automatic int base_w(input int fs);
    return imax(leak_w(fs), BIAS_W);
  endfunction

  function automatic int diff_w(input int fw, input int fs);
    return imax(fw, base_w(fs) + 1) + 1;
  endfunction

  function automatic int prod_w(input int fw, input int fs);
    return diff_w(fw, fs) + PCT_W;
  endfunction

  function automatic int lim_w(input int fw, input int fs);
    return diff_w(fw, fs) + 2;
  endfunction

  // Rounded-up reciprocal of 100 scaled by 2**sh.
  function automatic logic [63:0] recip(input int sh);
    return ((64'd1 << sh) + 64'd99) / 64'd100;
  endfunction

endpackage

@@ rtl/efct_front.sv @@
// ----------------------------------------------------------------------------
// efct_front
// Input register, flow smoothing filters and selection of peak, base and
// flow for the limit computation.
// ----------------------------------------------------------------------------
module efct_front #(
  parameter int FLOW_WIDTH = efct_pkg::FLOW_WIDTH_DEF,
  parameter int FLOW_SCALE = efct_pkg::FLOW_SCALE_DEF,
  localparam int LEAK_W = efct_pkg::leak_w(FLOW_SCALE),
  localparam int BASE_W = efct_pkg::base_w(FLOW_SCALE),
  localparam int DIFF_W = efct_pkg::diff_w(FLOW_WIDTH, FLOW_SCALE)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic signed [FLOW_WIDTH-1:0]        in_delivered,
  input  logic signed [FLOW_WIDTH-1:0]        in_proxy,
  input  logic signed [FLOW_WIDTH-1:0]        in_peak_delivered,
  input  logic signed [FLOW_WIDTH-1:0]        in_peak_proxy,
  input  logic [efct_pkg::LEAK_IN_W-1:0]      in_leak,
  input  logic                                in_proxy_ok,
  input  logic [efct_pkg::TICKS_W-1:0]        in_ticks,
  input  logic [efct_pkg::BIAS_W-1:0]         bias_flow,
  input  logic [efct_pkg::INIT_W-1:0]         init_phase_ticks,
  input  logic                                niv_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output efct_pkg::efct_ctl_t                 out_ctl,
  output logic signed [FLOW_WIDTH-1:0]        out_fd,
  output logic signed [FLOW_WIDTH-1:0]        out_fp,
  output logic signed [FLOW_WIDTH-1:0]        out_flow,
  output logic [BASE_W-1:0]                   out_base,
  output logic signed [DIFF_W-1:0]            out_diff
);

  logic                               v1;
  logic                               func1;
  logic signed [FLOW_WIDTH-1:0]       del1;
  logic signed [FLOW_WIDTH-1:0]       prx1;
  logic signed [FLOW_WIDTH-1:0]       pkd1;
  logic signed [FLOW_WIDTH-1:0]       pkp1;
  logic [LEAK_W-1:0]                  leak1;
  logic                               pok1;
  logic [efct_pkg::TICKS_W-1:0]       ticks1;

  logic signed [FLOW_WIDTH-1:0]       prev_fd;
  logic signed [FLOW_WIDTH-1:0]       prev_fp;

  logic                               rdy1;
  logic                               rdy2;
  logic signed [FLOW_WIDTH-1:0]       fd_next;
  logic signed [FLOW_WIDTH-1:0]       fp_next;
  logic                               use_prox;
  logic                               active;
  logic [BASE_W-1:0]                  base;
  logic signed [DIFF_W-1:0]           peak_x;
  logic signed [DIFF_W-1:0]           base_x;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      func1  <= in_func;
      del1   <= in_delivered;
      prx1   <= in_proxy;
      pkd1   <= in_peak_delivered;
      pkp1   <= in_peak_proxy;
      leak1  <= LEAK_W'(32'(in_leak) * 32'(FLOW_SCALE));
      pok1   <= in_proxy_ok;
      ticks1 <= in_ticks;
    end
  end

  always_comb begin
    fd_next  = (prev_fd >>> 1) + (del1 >>> 1);
    fp_next  = (prev_fp >>> 1) + (prx1 >>> 1);
    use_prox = !niv_mode && pok1;
    active   = ticks1 >= efct_pkg::TICKS_W'(init_phase_ticks);
    base     = use_prox ? BASE_W'(leak1) : BASE_W'(bias_flow);
    peak_x   = use_prox ? DIFF_W'(pkp1) : DIFF_W'(pkd1);
    base_x   = DIFF_W'({1'b0, base});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_fd   <= '0;
      prev_fp   <= '0;
    end else begin
      if (rdy2) begin
        out_valid <= v1;
      end
      if (rdy2 && v1) begin
        if (func1) begin
          prev_fd <= '0;
        end else begin
          prev_fd <= fd_next;
          prev_fp <= fp_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      out_ctl.enable <= func1;
      out_ctl.active <= !func1 && active;
      out_fd         <= func1 ? '0 : fd_next;
      out_fp         <= func1 ? prev_fp : fp_next;
      out_flow       <= use_prox ? fp_next : fd_next;
      out_base       <= base;
      out_diff       <= peak_x - base_x;
    end
  end

endmodule

@@ rtl/efct_scale.sv @@
// ----------------------------------------------------------------------------
// efct_scale
// Scales the peak-to-base difference by the sensitivity percent and divides
// by 100 with truncation toward zero, using a split reciprocal multiply.
// ----------------------------------------------------------------------------
module efct_scale #(
  parameter int FLOW_WIDTH = efct_pkg::FLOW_WIDTH_DEF,
  parameter int FLOW_SCALE = efct_pkg::FLOW_SCALE_DEF,
  localparam int BASE_W = efct_pkg::base_w(FLOW_SCALE),
  localparam int DIFF_W = efct_pkg::diff_w(FLOW_WIDTH, FLOW_SCALE)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [efct_pkg::PCT_W-1:0]    exh_sens_pct,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  efct_pkg::efct_ctl_t           in_ctl,
  input  logic signed [FLOW_WIDTH-1:0]  in_fd,
  input  logic signed [FLOW_WIDTH-1:0]  in_fp,
  input  logic signed [FLOW_WIDTH-1:0]  in_flow,
  input  logic [BASE_W-1:0]             in_base,
  input  logic signed [DIFF_W-1:0]      in_diff,
  output logic                          out_valid,
  input  logic                          out_ready,
  output efct_pkg::efct_ctl_t           out_ctl,
  output logic signed [FLOW_WIDTH-1:0]  out_fd,
  output logic signed [FLOW_WIDTH-1:0]  out_fp,
  output logic signed [FLOW_WIDTH-1:0]  out_flow,
  output logic [BASE_W-1:0]             out_base,
  output logic signed [DIFF_W:0]        out_quot
);

  localparam int PW     = efct_pkg::prod_w(FLOW_WIDTH, FLOW_SCALE);
  localparam int SH     = PW + 7;
  localparam int MW     = PW + 1;
  localparam int PL     = PW / 2;
  localparam int PH     = PW - PL;
  localparam int FULL_W = PW + MW + 1;
  localparam logic [MW-1:0] RECIP = MW'(efct_pkg::recip(SH));

  logic                          v3;
  logic                          v4;
  logic                          rdy3;
  logic                          rdy4;
  logic                          rdy5;

  efct_pkg::efct_ctl_t           ctl3;
  efct_pkg::efct_ctl_t           ctl4;
  logic signed [FLOW_WIDTH-1:0]  fd3;
  logic signed [FLOW_WIDTH-1:0]  fd4;
  logic signed [FLOW_WIDTH-1:0]  fp3;
  logic signed [FLOW_WIDTH-1:0]  fp4;
  logic signed [FLOW_WIDTH-1:0]  flow3;
  logic signed [FLOW_WIDTH-1:0]  flow4;
  logic [BASE_W-1:0]             base3;
  logic [BASE_W-1:0]             base4;
  logic                          neg3;
  logic                          neg4;
  logic [PW-1:0]                 prod3;
  logic [PL+MW-1:0]              ppl4;
  logic [PH+MW-1:0]              pph4;

  logic [efct_pkg::PCT_W-1:0]    pct_sat;
  logic [DIFF_W-1:0]             mag;
  logic [FULL_W-1:0]             full;
  logic signed [DIFF_W:0]        q_pos;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  always_comb begin
    pct_sat = (exh_sens_pct > efct_pkg::PCT_MAX) ? efct_pkg::PCT_MAX : exh_sens_pct;
    mag     = in_diff[DIFF_W-1] ? DIFF_W'(-in_diff) : DIFF_W'(in_diff);
    full    = (FULL_W'(pph4) << PL) + FULL_W'(ppl4);
    q_pos   = {1'b0, full[SH +: DIFF_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= in_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      ctl3  <= in_ctl;
      fd3   <= in_fd;
      fp3   <= in_fp;
      flow3 <= in_flow;
      base3 <= in_base;
      neg3  <= in_diff[DIFF_W-1];
      prod3 <= PW'(mag) * PW'(pct_sat);
    end
    if (rdy4 && v3) begin
      ctl4  <= ctl3;
      fd4   <= fd3;
      fp4   <= fp3;
      flow4 <= flow3;
      base4 <= base3;
      neg4  <= neg3;
      ppl4  <= (PL + MW)'(prod3[PL-1:0]) * (PL + MW)'(RECIP);
      pph4  <= (PH + MW)'(prod3[PW-1:PL]) * (PH + MW)'(RECIP);
    end
    if (rdy5 && v4) begin
      out_ctl  <= ctl4;
      out_fd   <= fd4;
      out_fp   <= fp4;
      out_flow <= flow4;
      out_base <= base4;
      out_quot <= neg4 ? -q_pos : q_pos;
    end
  end

endmodule

@@ rtl/efct_decide.sv @@
// ----------------------------------------------------------------------------
// efct_decide
// Adds the base to the scaled difference, compares the selected flow with
// the limit, keeps the sticky fire latch and holds the result register.
// ----------------------------------------------------------------------------
module efct_decide #(
  parameter int FLOW_WIDTH = efct_pkg::FLOW_WIDTH_DEF,
  parameter int FLOW_SCALE = efct_pkg::FLOW_SCALE_DEF,
  localparam int BASE_W = efct_pkg::base_w(FLOW_SCALE),
  localparam int DIFF_W = efct_pkg::diff_w(FLOW_WIDTH, FLOW_SCALE)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  efct_pkg::efct_ctl_t                in_ctl,
  input  logic signed [FLOW_WIDTH-1:0]       in_fd,
  input  logic signed [FLOW_WIDTH-1:0]       in_fp,
  input  logic signed [FLOW_WIDTH-1:0]       in_flow,
  input  logic [BASE_W-1:0]                  in_base,
  input  logic signed [DIFF_W:0]             in_quot,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_fired,
  output logic signed [FLOW_WIDTH-1:0]       out_fd,
  output logic signed [FLOW_WIDTH-1:0]       out_fp,
  output logic signed [efct_pkg::LIM_W-1:0]  out_limit
);

  localparam int LW   = efct_pkg::lim_w(FLOW_WIDTH, FLOW_SCALE);
  localparam int LIMW = efct_pkg::LIM_W;

  logic                     fire_latch;
  logic                     fire_latch_next;
  logic                     rdy;
  logic signed [LW-1:0]     lim;
  logic signed [LW-1:0]     flow_x;
  logic                     hit;
  logic                     ovf;
  logic signed [LIMW-1:0]   lim_sat;

  assign rdy      = !out_valid || out_ready;
  assign in_ready = rdy;

  always_comb begin
    lim    = LW'(in_quot) + LW'({1'b0, in_base});
    flow_x = LW'(in_flow);
    hit    = in_ctl.active && (flow_x < lim);
    fire_latch_next = in_ctl.enable ? 1'b0 : (fire_latch || hit);
    ovf    = !((&lim[LW-1:LIMW-1]) || !(|lim[LW-1:LIMW-1]));
    if (!in_ctl.active) begin
      lim_sat = '0;
    end else if (ovf) begin
      lim_sat = lim[LW-1] ? {1'b1, {(LIMW-1){1'b0}}} : {1'b0, {(LIMW-1){1'b1}}};
    end else begin
      lim_sat = lim[LIMW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      fire_latch <= 1'b0;
    end else begin
      if (rdy) begin
        out_valid <= in_valid;
      end
      if (rdy && in_valid) begin
        fire_latch <= fire_latch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      out_fired <= fire_latch_next;
      out_fd    <= in_fd;
      out_fp    <= in_fp;
      out_limit <= lim_sat;
    end
  end

endmodule

@@ rtl/exhalation_flow_cycle_trigger.sv @@
// ----------------------------------------------------------------------------
// exhalation_flow_cycle_trigger
// Expiratory cycle trigger: smooths flow, computes the cycle limit and keeps
// a sticky fired flag, one result item for every input item.
// Throughput: one item per cycle unless m_axis_tready stalls the output,
// through six register stages; the divide by 100 is a reciprocal multiply
// split over two of them.
// Reset: synchronous; clears all valid flags, both flow filters and the fire
// latch, and loads the registers with their default settings.
// ----------------------------------------------------------------------------
module exhalation_flow_cycle_trigger #(
  parameter int FLOW_WIDTH = efct_pkg::FLOW_WIDTH_DEF,
  parameter int FLOW_SCALE = efct_pkg::FLOW_SCALE_DEF,
  localparam int IN_TDATA_W  = ((4 * FLOW_WIDTH + 33 + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * FLOW_WIDTH + 26 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // delivered_flow, proxy_flow, peak_delivered, peak_proxy, exh_leak,
  // proxy_ok, phase_ticks
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,
  // func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fired, filt_delivered, filt_proxy, limit_value
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [efct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [efct_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FW     = FLOW_WIDTH;
  localparam int BASE_W = efct_pkg::base_w(FLOW_SCALE);
  localparam int DIFF_W = efct_pkg::diff_w(FLOW_WIDTH, FLOW_SCALE);
  localparam int LK     = 4 * FW;
  localparam int OK     = LK + efct_pkg::LEAK_IN_W;
  localparam int TK     = OK + 1;

  logic [efct_pkg::PCT_W-1:0]   exh_sens_pct;
  logic [efct_pkg::BIAS_W-1:0]  bias_flow;
  logic [efct_pkg::INIT_W-1:0]  init_phase_ticks;
  logic                         niv_mode;

  logic                         f_valid;
  logic                         f_ready;
  efct_pkg::efct_ctl_t          f_ctl;
  logic signed [FW-1:0]         f_fd;
  logic signed [FW-1:0]         f_fp;
  logic signed [FW-1:0]         f_flow;
  logic [BASE_W-1:0]            f_base;
  logic signed [DIFF_W-1:0]     f_diff;

  logic                         s_valid;
  logic                         s_ready;
  efct_pkg::efct_ctl_t          s_ctl;
  logic signed [FW-1:0]         s_fd;
  logic signed [FW-1:0]         s_fp;
  logic signed [FW-1:0]         s_flow;
  logic [BASE_W-1:0]            s_base;
  logic signed [DIFF_W:0]       s_quot;

  logic                         fired;
  logic signed [FW-1:0]         filt_delivered;
  logic signed [FW-1:0]         filt_proxy;
  logic signed [efct_pkg::LIM_W-1:0] limit_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exh_sens_pct     <= efct_pkg::SENS_RESET;
      bias_flow        <= efct_pkg::BIAS_RESET;
      init_phase_ticks <= efct_pkg::INIT_RESET;
      niv_mode         <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        efct_pkg::REG_EXH_SENS_PCT:     exh_sens_pct     <= cfg_data[efct_pkg::PCT_W-1:0];
        efct_pkg::REG_BIAS_FLOW:        bias_flow        <= cfg_data[efct_pkg::BIAS_W-1:0];
        efct_pkg::REG_INIT_PHASE_TICKS: init_phase_ticks <= cfg_data[efct_pkg::INIT_W-1:0];
        efct_pkg::REG_NIV_MODE:         niv_mode         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  efct_front #(
    .FLOW_WIDTH(FLOW_WIDTH),
    .FLOW_SCALE(FLOW_SCALE)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_func           (s_axis_tuser),
    .in_delivered      (s_axis_tdata[FW-1:0]),
    .in_proxy          (s_axis_tdata[2*FW-1:FW]),
    .in_peak_delivered (s_axis_tdata[3*FW-1:2*FW]),
    .in_peak_proxy     (s_axis_tdata[4*FW-1:3*FW]),
    .in_leak           (s_axis_tdata[OK-1:LK]),
    .in_proxy_ok       (s_axis_tdata[OK]),
    .in_ticks          (s_axis_tdata[TK+efct_pkg::TICKS_W-1:TK]),
    .bias_flow         (bias_flow),
    .init_phase_ticks  (init_phase_ticks),
    .niv_mode          (niv_mode),
    .out_valid         (f_valid),
    .out_ready         (f_ready),
    .out_ctl           (f_ctl),
    .out_fd            (f_fd),
    .out_fp            (f_fp),
    .out_flow          (f_flow),
    .out_base          (f_base),
    .out_diff          (f_diff)
  );

  efct_scale #(
    .FLOW_WIDTH(FLOW_WIDTH),
    .FLOW_SCALE(FLOW_SCALE)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .exh_sens_pct (exh_sens_pct),
    .in_valid     (f_valid),
    .in_ready     (f_ready),
    .in_ctl       (f_ctl),
    .in_fd        (f_fd),
    .in_fp        (f_fp),
    .in_flow      (f_flow),
    .in_base      (f_base),
    .in_diff      (f_diff),
    .out_valid    (s_valid),
    .out_ready    (s_ready),
    .out_ctl      (s_ctl),
    .out_fd       (s_fd),
    .out_fp       (s_fp),
    .out_flow     (s_flow),
    .out_base     (s_base),
    .out_quot     (s_quot)
  );

  efct_decide #(
    .FLOW_WIDTH(FLOW_WIDTH),
    .FLOW_SCALE(FLOW_SCALE)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_ctl    (s_ctl),
    .in_fd     (s_fd),
    .in_fp     (s_fp),
    .in_flow   (s_flow),
    .in_base   (s_base),
    .in_quot   (s_quot),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_fired (fired),
    .out_fd    (filt_delivered),
    .out_fp    (filt_proxy),
    .out_limit (limit_value)
  );

  assign m_axis_tdata = OUT_TDATA_W'({limit_value, filt_proxy, filt_delivered, fired});

endmodule

@@ rtl/efct_checker.sv @@
// ----------------------------------------------------------------------------
// efct_checker
// Port-level checks of the exhalation flow cycle trigger, bound to the top
// level.
// ----------------------------------------------------------------------------
module efct_checker #(
  parameter int FLOW_WIDTH = efct_pkg::FLOW_WIDTH_DEF,
  localparam int OUT_TDATA_W = ((2 * FLOW_WIDTH + 26 + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int FW = FLOW_WIDTH;
  localparam int LB = 2 * FW + 1;

  logic last_fired;
  logic out_take;

  assign out_take = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_fired <= 1'b0;
    end else if (out_take) begin
      last_fired <= m_axis_tdata[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while no result is pending");

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    out_take && last_fired && !m_axis_tdata[0] |->
      (m_axis_tdata[FW:1] == '0) && (m_axis_tdata[LB+efct_pkg::LIM_W-1:LB] == '0))
    else $error("fired flag dropped without an enable item");

endmodule

bind exhalation_flow_cycle_trigger efct_checker #(
  .FLOW_WIDTH(FLOW_WIDTH)
) u_efct_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exhalation flow cycle trigger. A directed table
// covers field extremes, the init-phase boundary and restarts. Randomized
// breaths follow, with decaying flow and random content under several
// register settings. Results are checked against predictions or table rows.
// ----------------------------------------------------------------------------
module tb_top;
  import efct_pkg::*;

  localparam int FW = FLOW_WIDTH_DEF;
  localparam int IN_W = ((4 * FW + 33 + 7) / 8) * 8;
  localparam int OUT_W = ((2 * FW + 26 + 7) / 8) * 8;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 185;
  localparam int IDLE_PCT = 29;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDX_TOP = (1 << CFG_IDX_W) - 1;
  localparam int DIR_ROWS = 15;
  localparam longint LIM_HI = (longint'(1) << (LIM_W - 1)) - 1;
  localparam longint LIM_LO = -(longint'(1) << (LIM_W - 1));
  localparam logic signed [FW-1:0] FLOW_MAX = {1'b0, {(FW - 1){1'b1}}};
  localparam logic signed [FW-1:0] FLOW_MIN = {1'b1, {(FW - 1){1'b0}}};

  typedef enum bit {FN_TICK = 1'b0, FN_ENABLE = 1'b1} func_t;

  typedef struct packed {
    func_t                  func;
    logic signed [FW-1:0]   del;
    logic signed [FW-1:0]   prx;
    logic signed [FW-1:0]   pk_del;
    logic signed [FW-1:0]   pk_prx;
    logic [LEAK_IN_W-1:0]   leak;
    logic                   prx_ok;
    logic [TICKS_W-1:0]     ticks;
  } flow_item_t;

  typedef struct packed {
    logic                    fired;
    logic signed [FW-1:0]    filt_del;
    logic signed [FW-1:0]    filt_prx;
    logic signed [LIM_W-1:0] limit;
  } trig_result_t;

  typedef struct packed {
    flow_item_t   it;
    logic         typed;
    trig_result_t exp;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic signed [FW-1:0] filt_del_q;
  logic signed [FW-1:0] filt_prx_q;
  logic                 latch_q;
  logic [PCT_W-1:0]     sens_q;
  logic [BIAS_W-1:0]    bias_q;
  logic [INIT_W-1:0]    init_q;
  logic                 niv_q;

  trig_result_t pending_results[$];
  bit calm = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{FN_TICK, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
    '{'{FN_TICK, FLOW_MAX, FLOW_MIN, 0, 0, 0, 0, 0}, 1'b1,
      '{0, 24'sd4194303, -24'sd4194304, 0}},
    '{'{FN_ENABLE, FLOW_MIN, FLOW_MAX, FLOW_MAX, FLOW_MIN, 16'hFFFF, 1, 16'hFFFF}, 1'b1,
      '{0, 0, -24'sd4194304, 0}},
    '{'{FN_TICK, FLOW_MIN, FLOW_MAX, FLOW_MAX, FLOW_MIN, 16'hFFFF, 1, 16'hFFFF}, 1'b0, '0},
    '{'{FN_TICK, 1000, -1000, 2000000, 2000000, 100, 0, 99}, 1'b0, '0},
    '{'{FN_TICK, 1000, -1000, 2000000, 2000000, 100, 0, 100}, 1'b0, '0},
    '{'{FN_TICK, FLOW_MAX, FLOW_MAX, 0, 0, 0, 0, 0}, 1'b0, '0},
    '{'{FN_ENABLE, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
    '{'{FN_TICK, 4000000, 4000000, -1, FLOW_MAX, 0, 1, 200}, 1'b0, '0},
    '{'{FN_TICK, -1, -1, FLOW_MIN, FLOW_MAX, 16'hFFFF, 1, 16'h8000}, 1'b0, '0},
    '{'{FN_TICK, 1, 1, FLOW_MIN, FLOW_MIN, 0, 0, 300}, 1'b0, '0},
    '{'{FN_TICK, 24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555, 16'h5555, 1, 16'hAAAA},
      1'b0, '0},
    '{'{FN_TICK, 24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA, 16'hAAAA, 0, 16'h5555},
      1'b0, '0},
    '{'{FN_ENABLE, FLOW_MAX, FLOW_MIN, -1, 1, 1, 1, 1}, 1'b0, '0},
    '{'{FN_TICK, 0, 0, 0, 0, 0, 0, 100}, 1'b0, '0}
  };

  exhalation_flow_cycle_trigger u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic predict_trigger(input flow_item_t it, output trig_result_t r);
    longint fd, fp, pct, peak, base, flow, lim;
    bit use_prx;
    lim = 0;
    if (it.func == FN_ENABLE) begin
      filt_del_q = '0;
      latch_q = 1'b0;
      r = '{1'b0, '0, filt_prx_q, '0};
    end else begin
      fd = longint'(filt_del_q >>> 1) + longint'(it.del >>> 1);
      fp = longint'(filt_prx_q >>> 1) + longint'(it.prx >>> 1);
      filt_del_q = fd[FW-1:0];
      filt_prx_q = fp[FW-1:0];
      if (it.ticks >= init_q) begin
        pct = (sens_q > PCT_MAX) ? longint'(PCT_MAX) : longint'(sens_q);
        use_prx = !niv_q && it.prx_ok;
        peak = use_prx ? longint'(it.pk_prx) : longint'(it.pk_del);
        base = use_prx ? longint'(it.leak) * FLOW_SCALE_DEF : longint'(bias_q);
        flow = use_prx ? fp : fd;
        lim = (pct * (peak - base)) / 100 + base;
        if (flow < lim) begin
          latch_q = 1'b1;
        end
      end
      if (lim > LIM_HI) begin
        lim = LIM_HI;
      end
      if (lim < LIM_LO) begin
        lim = LIM_LO;
      end
      r = '{latch_q, filt_del_q, filt_prx_q, lim[LIM_W-1:0]};
    end
  endtask

  // Called at a falling edge, returns at a falling edge with valid left high.
  task automatic send_item(input flow_item_t it, input bit typed, input trig_result_t fixed);
    trig_result_t want;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({it.ticks, it.prx_ok, it.leak, it.pk_prx, it.pk_del, it.prx,
                           it.del});
    s_axis_tuser <= it.func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_trigger(it, want);
    pending_results.push_back(typed ? fixed : want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_EXH_SENS_PCT:     sens_q = val[PCT_W-1:0];
      REG_BIAS_FLOW:        bias_q = val[BIAS_W-1:0];
      REG_INIT_PHASE_TICKS: init_q = val[INIT_W-1:0];
      REG_NIV_MODE:         niv_q = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic settle;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int p);
    logic [CFG_DATA_W-1:0] sens, bias, init, niv;
    sens = {16'($urandom), 7'($urandom_range(0, 127))};
    bias = 23'($urandom);
    init = ($urandom_range(0, 3) == 0) ? 23'($urandom)
                                        : {13'($urandom), 10'($urandom_range(0, 60))};
    niv = 23'($urandom);
    case (p)
      0: begin
        sens = 23'd127;
        bias = {BIAS_W{1'b1}};
        init = '0;
        niv = '0;
      end
      1: begin
        sens = '0;
        bias = '0;
        init = 23'd1023;
        niv = 23'd1;
      end
      2: begin
        sens = 23'(PCT_MAX);
        init = 23'd1;
        niv = '0;
      end
      default: ;
    endcase
    write_reg(REG_EXH_SENS_PCT, sens);
    write_reg(REG_BIAS_FLOW, bias);
    write_reg(REG_INIT_PHASE_TICKS, init);
    write_reg(REG_NIV_MODE, niv);
    if (p == 0 || $urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_NIV_MODE) + 1, IDX_TOP)), 23'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic flow_item_t random_item();
    flow_item_t it;
    it.func = func_t'($urandom_range(0, 1));
    it.del = FW'($urandom);
    it.prx = FW'($urandom);
    it.pk_del = FW'($urandom);
    it.pk_prx = FW'($urandom);
    it.leak = LEAK_IN_W'($urandom);
    it.prx_ok = 1'($urandom);
    it.ticks = TICKS_W'($urandom);
    return it;
  endfunction

  function automatic logic signed [FW-1:0] clamp_flow(input longint v);
    if (v > longint'(FLOW_MAX)) begin
      return FLOW_MAX;
    end
    if (v < longint'(FLOW_MIN)) begin
      return FLOW_MIN;
    end
    return v[FW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] pick_peak();
    if ($urandom_range(0, 99) < 30) begin
      return FW'($urandom);
    end
    return FW'($urandom_range(0, int'(FLOW_MAX)));
  endfunction

  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    trig_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.fired = m_axis_tdata[0];
      got.filt_del = m_axis_tdata[FW:1];
      got.filt_prx = m_axis_tdata[2*FW:FW+1];
      got.limit = m_axis_tdata[2*FW+LIM_W:2*FW+1];
      results_seen++;
      if (got.fired) begin
        fired_seen++;
      end
      if (pending_results.size() == 0) begin
        report("result with none expected, limit", longint'(got.limit), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.fired !== want.fired) begin
          report("fired", longint'(got.fired), longint'(want.fired));
        end
        if (got.filt_del !== want.filt_del) begin
          report("filt_delivered", longint'(got.filt_del), longint'(want.filt_del));
        end
        if (got.filt_prx !== want.filt_prx) begin
          report("filt_proxy", longint'(got.filt_prx), longint'(want.filt_prx));
        end
        if (got.limit !== want.limit) begin
          report("limit_value", longint'(got.limit), longint'(want.limit));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    flow_item_t it;
    logic signed [FW-1:0] pk_d, pk_p;
    longint tick0;
    int len, sent;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    filt_del_q = '0;
    filt_prx_q = '0;
    latch_q = 1'b0;
    sens_q = SENS_RESET;
    bias_q = BIAS_RESET;
    init_q = INIT_RESET;
    niv_q = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].exp);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure(p);
      calm = (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 75) begin
          // A restart followed by one breath of decaying flow whose ticks run near the
          // end of the initial phase.
          len = $urandom_range(4, 30);
          pk_d = pick_peak();
          pk_p = pick_peak();
          tick0 = longint'(init_q) - longint'($urandom_range(0, len));
          if (tick0 < 0) begin
            tick0 = 0;
          end
          it = random_item();
          it.func = FN_ENABLE;
          send_item(it, 1'b0, '0);
          for (int k = 0; k < len; k++) begin
            it = random_item();
            it.func = FN_TICK;
            it.pk_del = pk_d;
            it.pk_prx = pk_p;
            it.del = clamp_flow(longint'(pk_d) * (len - k) / len +
                                longint'($urandom_range(0, 40000)) - 20000);
            it.prx = clamp_flow(longint'(pk_p) * (len - k) / len +
                                longint'($urandom_range(0, 40000)) - 20000);
            if ($urandom_range(0, 9) != 0) begin
              it.leak = LEAK_IN_W'($urandom_range(0, 3000));
            end
            it.prx_ok = ($urandom_range(0, 9) != 0);
            it.ticks = (tick0 + k > 65535) ? 16'hFFFF : TICKS_W'(tick0 + k);
            send_item(it, 1'b0, '0);
          end
          sent += len + 1;
        end else begin
          send_item(random_item(), 1'b0, '0);
          sent++;
        end
      end
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report("results never delivered", pending_results.size(), 0);
    end
    $display("summary: %0d items sent, %0d results checked, %0d with the trigger fired",
             items_sent, results_seen, fired_seen);
    $display("summary: %0d register writes over %0d settings, %0d mismatches",
             cfg_writes, PHASES + 1, errors);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
